@@ design/gregorian_date_unit_top_defines.svh @@
// ----------------------------------------------------------------------------
// Gregorian date unit assertion macros
// Concurrent assertion helpers used by the top level to check the design.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_UNIT_TOP_DEFINES_SVH
`define GREGORIAN_DATE_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define GDU_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GDU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define GDU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define GDU_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define GDU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define GDU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ design/gdu_pkg.sv @@
// ----------------------------------------------------------------------------
// Gregorian date unit package
// Word types, command and status types, calendar constants and functions.
// ----------------------------------------------------------------------------
package gdu_pkg;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_SET  = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_DIFF = 2'd2;

    // Calendar constants.
    localparam logic [13:0] DEF_YEAR  = 14'd1970;
    localparam logic [3:0]  DEF_MONTH = 4'd1;
    localparam logic [4:0]  DEF_DAY   = 5'd1;
    localparam logic [13:0] MAX_YEAR  = 14'd9999;
    localparam logic [8:0]  YEAR_DAYS = 9'd365;
    localparam logic [7:0]  DN_BIAS   = 8'd62;
    // Reciprocal of 100 scaled by 2**19, exact for every 14-bit year.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Input word.
    typedef struct packed {
        logic [1:0]  func;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [15:0] day_count;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [21:0] day_number;
        logic [21:0] difference;
        logic        input_valid;
    } out_word_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_IN_Q,
        CMD_IN_CHK,
        CMD_SET,
        CMD_ADD_Q,
        CMD_ADD_STEP,
        CMD_DN_Q,
        CMD_DN_SUM,
        CMD_DN_FIN,
        CMD_DIFF,
        CMD_LOAD_OUT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    sel_b;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       cnt_zero;
        logic       fits;
        logic       year_end;
        logic       last_year;
    } status_t;

    // Quotient of a year by 100 through the scaled reciprocal.
    function automatic logic [7:0] div100(input logic [13:0] y);
        logic [26:0] prod;
        begin
            prod = 27'(y) * 27'(RECIP_100);
            return prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    endfunction

    // Leap year test, given the year and its quotient by 100.
    function automatic logic leap_year(input logic [13:0] y, input logic [7:0] q);
        logic [14:0] q100;
        logic        cent;
        begin
            q100 = {1'b0, q, 6'b0} + {2'b0, q, 5'b0} + {5'b0, q, 2'b0};
            cent = (q100 == {1'b0, y});
            return cent ? (q[1:0] == 2'd0) : (y[1:0] == 2'd0);
        end
    endfunction

    // Length of a month; zero for a month code that is not a month.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        begin
            case (m)
                4'd2:                         return leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:      return 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7,
                4'd8, 4'd10, 4'd12:           return 5'd31;
                default:                      return 5'd0;
            endcase
        end
    endfunction

    // Days before the month in a year that starts in March.
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        begin
            case (m)
                4'd3:    return 9'd0;
                4'd4:    return 9'd31;
                4'd5:    return 9'd61;
                4'd6:    return 9'd92;
                4'd7:    return 9'd122;
                4'd8:    return 9'd153;
                4'd9:    return 9'd184;
                4'd10:   return 9'd214;
                4'd11:   return 9'd245;
                4'd12:   return 9'd275;
                4'd1:    return 9'd306;
                4'd2:    return 9'd337;
                default: return 9'd0;
            endcase
        end
    endfunction

    // Legal date test.
    function automatic logic legal_date(input logic [13:0] y, input logic [3:0] m,
                                        input logic [4:0] d, input logic leap);
        logic [4:0] len;
        begin
            len = month_len(m, leap);
            return (y != 14'd0) && (y <= MAX_YEAR) && (d != 5'd0) && (d <= len);
        end
    endfunction

endpackage

@@ design/gregorian_date_unit_top.sv @@
// ----------------------------------------------------------------------------
// Gregorian date unit
// Holds one date; sets it, adds days to it, or measures days to another date.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Word
//   input     in_valid / in_stall  in_word  (func, date, day count)
//   output    out_valid / out_stall out_word (stored date, day number, diff)
//
// One word is worked on at a time, through to its result word. Adding days steps
// the date one month at a time in the month-stepping loop, with an extra quotient
// step for each year crossed. Reset sets the stored date to 1970-01-01 and empties
// the result register. A new word is taken while a result still waits; a stalled
// result holds the sequencer only in its last step.
//
module gregorian_date_unit_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gdu_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output gdu_pkg::out_word_t out_word
);
    import gdu_pkg::*;

`include "gregorian_date_unit_top_defines.svh"

    cmd_t    cmd;
    status_t sts;
    logic    out_date_ok;

    // Sequencer.
    gdu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Date registers and arithmetic.
    gdu_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (out_word)
    );

    // The reported date lies within the supported calendar range.
    assign out_date_ok = (out_word.out_year >= 14'd1) && (out_word.out_year <= MAX_YEAR)
                      && (out_word.out_month >= 4'd1) && (out_word.out_month <= 4'd12)
                      && (out_word.out_day >= 5'd1);

    // An accepted word keeps the input side busy in the next cycle.
    `GDU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "busy")

    // A result appears only at the end of a sequence.
    `GDU_ASSERT_SAME(a_result_src, clk, rst_n, $rose(out_valid), $past(in_stall), "stray result")

    // A valid result word always reports a date within the supported calendar range.
    `GDU_ASSERT_SAME(a_date_legal, clk, rst_n, out_valid, out_date_ok, "illegal stored date")

endmodule

@@ design/gdu_ctrl.sv @@
// ----------------------------------------------------------------------------
// Gregorian date unit controller
// Sequences the datapath through check, set, add, day number and difference steps.
// ----------------------------------------------------------------------------
module gdu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  gdu_pkg::status_t sts,
    output gdu_pkg::cmd_t    cmd
);
    import gdu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IN_Q,
        ST_IN_CHK,
        ST_SET,
        ST_ADD_Q,
        ST_ADD_STEP,
        ST_DN_Q,
        ST_DN_SUM,
        ST_DN_FIN,
        ST_DIFF,
        ST_FINISH
    } state_t;

    state_t  state_reg, state_next;
    logic    sel_b_reg, sel_b_next;
    logic    out_valid_reg, out_valid_next;
    cmd_op_t op;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        sel_b_next     = sel_b_reg;
        out_valid_next = out_valid_reg && out_stall;
        op             = CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = CMD_CAPTURE;
                    state_next = ST_IN_Q;
                end
            end
            ST_IN_Q:
            begin
                op         = CMD_IN_Q;
                state_next = ST_IN_CHK;
            end
            ST_IN_CHK:
            begin
                op = CMD_IN_CHK;
                if (sts.func == FUNC_SET)
                begin
                    state_next = ST_SET;
                end
                else if (sts.func == FUNC_ADD)
                begin
                    state_next = ST_ADD_Q;
                end
                else if (sts.func == FUNC_DIFF)
                begin
                    sel_b_next = 1'b1;
                    state_next = ST_DN_Q;
                end
                else
                begin
                    state_next = ST_DN_Q;
                end
            end
            ST_SET:
            begin
                op         = CMD_SET;
                state_next = ST_DN_Q;
            end
            ST_ADD_Q:
            begin
                op         = CMD_ADD_Q;
                state_next = ST_ADD_STEP;
            end
            ST_ADD_STEP:
            begin
                op = CMD_ADD_STEP;
                if (sts.cnt_zero || sts.fits)
                begin
                    state_next = ST_DN_Q;
                end
                else if (sts.year_end)
                begin
                    state_next = sts.last_year ? ST_DN_Q : ST_ADD_Q;
                end
            end
            ST_DN_Q:
            begin
                op         = CMD_DN_Q;
                state_next = ST_DN_SUM;
            end
            ST_DN_SUM:
            begin
                op         = CMD_DN_SUM;
                state_next = ST_DN_FIN;
            end
            ST_DN_FIN:
            begin
                op = CMD_DN_FIN;
                if (sel_b_reg)
                begin
                    sel_b_next = 1'b0;
                    state_next = ST_DN_Q;
                end
                else if (sts.func == FUNC_DIFF)
                begin
                    state_next = ST_DIFF;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIFF:
            begin
                op         = CMD_DIFF;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // The result register is free or is being emptied this cycle.
                if (!out_valid_reg || !out_stall)
                begin
                    op             = CMD_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_b_reg     <= sel_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.op    = op;
    assign cmd.sel_b = sel_b_reg;

endmodule

@@ design/gdu_datapath.sv @@
// ----------------------------------------------------------------------------
// Gregorian date unit datapath
// Stored date, input date check, month stepping, day number and difference arithmetic.
// ----------------------------------------------------------------------------
module gdu_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  gdu_pkg::in_word_t  in_word,
    input  gdu_pkg::cmd_t      cmd,
    output gdu_pkg::status_t   sts,
    output gdu_pkg::out_word_t out_word
);
    import gdu_pkg::*;

    // Stored date.
    logic [13:0] cy_reg, cy_next;
    logic [3:0]  cm_reg, cm_next;
    logic [4:0]  cd_reg, cd_next;

    // Captured input word and check result.
    logic [1:0]  func_reg, func_next;
    logic [13:0] iy_reg, iy_next;
    logic [3:0]  im_reg, im_next;
    logic [4:0]  id_reg, id_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        ok_reg, ok_next;

    // Year quotient and day number pipeline.
    logic [7:0]  q_reg, q_next;
    logic [13:0] yp_reg, yp_next;
    logic [8:0]  md_reg, md_next;
    logic [21:0] p1_reg, p1_next;
    logic [9:0]  p2_reg, p2_next;
    logic [7:0]  p3_reg, p3_next;
    logic [21:0] dn_reg, dn_next;
    logic [21:0] dnb_reg, dnb_next;
    logic [21:0] diff_reg, diff_next;
    out_word_t   out_reg, out_next;

    logic        cur_leap;
    logic [4:0]  cur_len;
    logic [4:0]  room;
    logic [15:0] step;
    logic [13:0] ysel;
    logic [3:0]  msel;
    logic [4:0]  dsel;
    logic [13:0] yp;
    logic [22:0] prod365;
    logic [21:0] dn_sum;

    // Month length of the stored date and the days left in its month.
    assign cur_leap = leap_year(cy_reg, q_reg);
    assign cur_len  = month_len(cm_reg, cur_leap);
    assign room     = cur_len - cd_reg;
    assign step     = {11'b0, room} + 16'd1;

    // Operand for the day number: the checked input date or the stored date.
    always_comb
    begin
        if (cmd.sel_b)
        begin
            ysel = ok_reg ? iy_reg : DEF_YEAR;
            msel = ok_reg ? im_reg : DEF_MONTH;
            dsel = ok_reg ? id_reg : DEF_DAY;
        end
        else
        begin
            ysel = cy_reg;
            msel = cm_reg;
            dsel = cd_reg;
        end
    end

    // January and February belong to the previous year.
    assign yp      = ysel - {13'b0, (msel < 4'd3)};
    assign prod365 = 23'(yp_reg) * 23'(YEAR_DAYS);
    assign dn_sum  = p1_reg + {12'b0, p2_reg} - {14'b0, p3_reg};

    // Operation decode.
    always_comb
    begin
        cy_next   = cy_reg;
        cm_next   = cm_reg;
        cd_next   = cd_reg;
        func_next = func_reg;
        iy_next   = iy_reg;
        im_next   = im_reg;
        id_next   = id_reg;
        cnt_next  = cnt_reg;
        ok_next   = ok_reg;
        q_next    = q_reg;
        yp_next   = yp_reg;
        md_next   = md_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        p3_next   = p3_reg;
        dn_next   = dn_reg;
        dnb_next  = dnb_reg;
        diff_next = diff_reg;
        out_next  = out_reg;
        case (cmd.op)
            CMD_CAPTURE:
            begin
                func_next = in_word.func;
                iy_next   = in_word.in_year;
                im_next   = in_word.in_month;
                id_next   = in_word.in_day;
                cnt_next  = in_word.day_count;
                diff_next = 22'd0;
            end
            CMD_IN_Q:
            begin
                q_next = div100(iy_reg);
            end
            CMD_IN_CHK:
            begin
                ok_next = legal_date(iy_reg, im_reg, id_reg, leap_year(iy_reg, q_reg));
            end
            CMD_SET:
            begin
                cy_next = ok_reg ? iy_reg : DEF_YEAR;
                cm_next = ok_reg ? im_reg : DEF_MONTH;
                cd_next = ok_reg ? id_reg : DEF_DAY;
            end
            CMD_ADD_Q:
            begin
                q_next = div100(cy_reg);
            end
            CMD_ADD_STEP:
            begin
                // Finish inside the month, or jump to the first of the next one.
                if (sts.cnt_zero)
                begin
                    cnt_next = cnt_reg;
                end
                else if (sts.fits)
                begin
                    cd_next  = cd_reg + cnt_reg[4:0];
                    cnt_next = 16'd0;
                end
                else
                begin
                    cnt_next = cnt_reg - step;
                    cd_next  = 5'd1;
                    if (sts.year_end)
                    begin
                        cm_next = 4'd1;
                        if (sts.last_year)
                        begin
                            // Stepping past the last date falls back to the default.
                            cy_next = DEF_YEAR;
                            cm_next = DEF_MONTH;
                            cd_next = DEF_DAY;
                        end
                        else
                        begin
                            cy_next = cy_reg + 14'd1;
                        end
                    end
                    else
                    begin
                        cm_next = cm_reg + 4'd1;
                    end
                end
            end
            CMD_DN_Q:
            begin
                yp_next = yp;
                q_next  = div100(yp);
                md_next = month_offset(msel) + {4'b0, dsel};
            end
            CMD_DN_SUM:
            begin
                p1_next = prod365[21:0] + {10'b0, yp_reg[13:2]};
                p2_next = {1'b0, md_reg} + {4'b0, q_reg[7:2]};
                p3_next = q_reg + DN_BIAS;
            end
            CMD_DN_FIN:
            begin
                if (cmd.sel_b)
                begin
                    dnb_next = dn_sum;
                end
                else
                begin
                    dn_next = dn_sum;
                end
            end
            CMD_DIFF:
            begin
                diff_next = (dn_reg > dnb_reg) ? (dn_reg - dnb_reg) : (dnb_reg - dn_reg);
            end
            CMD_LOAD_OUT:
            begin
                out_next.out_year    = cy_reg;
                out_next.out_month   = cm_reg;
                out_next.out_day     = cd_reg;
                out_next.day_number  = dn_reg;
                out_next.difference  = diff_reg;
                out_next.input_valid = ok_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Stored date.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cy_reg <= DEF_YEAR;
            cm_reg <= DEF_MONTH;
            cd_reg <= DEF_DAY;
        end
        else
        begin
            cy_reg <= cy_next;
            cm_reg <= cm_next;
            cd_reg <= cd_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        iy_reg   <= iy_next;
        im_reg   <= im_next;
        id_reg   <= id_next;
        cnt_reg  <= cnt_next;
        ok_reg   <= ok_next;
        q_reg    <= q_next;
        yp_reg   <= yp_next;
        md_reg   <= md_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        p3_reg   <= p3_next;
        dn_reg   <= dn_next;
        dnb_reg  <= dnb_next;
        diff_reg <= diff_next;
        out_reg  <= out_next;
    end

    // Status toward the controller.
    assign sts.func      = func_reg;
    assign sts.cnt_zero  = (cnt_reg == 16'd0);
    assign sts.fits      = (cnt_reg <= {11'b0, room});
    assign sts.year_end  = (cm_reg == 4'd12);
    assign sts.last_year = (cy_reg == MAX_YEAR);
    assign out_word      = out_reg;

endmodule
